/* src/pstm_pkg.sv */
// ----------------------------------------------------------------------------
// pstm_pkg
// Shared types and constants for the pot soft-takeover mixer.
// ----------------------------------------------------------------------------
package pstm_pkg;

	localparam int NUM_LEVELS = 3;
	localparam int LVL_W      = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;

	localparam int RAW_W  = 12;
	localparam int PCT_W  = 7;
	localparam int JOY_W  = 2;
	localparam int LVL_OW = 2;
	localparam int DIR_W  = 2;
	localparam int CFG_W  = 7;
	localparam int CIDX_W = 1;

	localparam logic [RAW_W-1:0] RAW_FULL = 12'd4095;
	localparam logic [PCT_W-1:0] PCT_FULL = 7'd100;

	localparam logic [CFG_W-1:0] THRESHOLD_RST = 7'd2;
	localparam logic [CFG_W-1:0] WINDOW_RST    = 7'd20;

	typedef enum logic [CIDX_W-1:0] {
		CFG_THRESHOLD = 1'b0,
		CFG_WINDOW    = 1'b1
	} cfg_idx_t;

	localparam logic [JOY_W-1:0] JOY_NONE  = 2'd0;
	localparam logic [JOY_W-1:0] JOY_UP    = 2'd1;
	localparam logic [JOY_W-1:0] JOY_DOWN  = 2'd2;
	localparam logic [JOY_W-1:0] JOY_SPARE = 2'd3;

	localparam logic signed [DIR_W-1:0] DIR_NONE  = 2'sb00;
	localparam logic signed [DIR_W-1:0] DIR_ABOVE = 2'sb01;
	localparam logic signed [DIR_W-1:0] DIR_BELOW = 2'sb11;

	typedef struct packed {
		logic                    caught;
		logic                    changed;
		logic signed [DIR_W-1:0] dir;
		logic [PCT_W-1:0]        store_next;
	} pstm_side_t;

endpackage

/* src/pstm_if.sv */
// ----------------------------------------------------------------------------
// pstm_in_if / pstm_out_if
// Valid/ready channels for pot sample requests and mixer results.
// ----------------------------------------------------------------------------
interface pstm_in_if import pstm_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [RAW_W-1:0] left_raw;
	logic [RAW_W-1:0] right_raw;
	logic [JOY_W-1:0] joystick;

	modport source (output valid, left_raw, right_raw, joystick, input ready);
	modport sink (input valid, left_raw, right_raw, joystick, output ready);
endinterface

interface pstm_out_if import pstm_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [LVL_OW-1:0]       level_used;
	logic [LVL_OW-1:0]       level_next;
	logic [PCT_W-1:0]        left_percent;
	logic [PCT_W-1:0]        right_percent;
	logic                    left_caught;
	logic                    right_caught;
	logic signed [DIR_W-1:0] left_drift_dir;
	logic signed [DIR_W-1:0] right_drift_dir;
	logic                    display_changed;

	modport source (output valid, level_used, level_next, left_percent, right_percent,
		left_caught, right_caught, left_drift_dir, right_drift_dir, display_changed,
		input ready);
	modport sink (input valid, level_used, level_next, left_percent, right_percent,
		left_caught, right_caught, left_drift_dir, right_drift_dir, display_changed,
		output ready);
endinterface

/* src/pstm_scale.sv */
// ----------------------------------------------------------------------------
// pstm_scale
// Scales a 12-bit pot sample to a truncated percent, raw*100/4095.
// ----------------------------------------------------------------------------
module pstm_scale import pstm_pkg::*; (
	input  logic [RAW_W-1:0] raw,
	output logic [PCT_W-1:0] pct
);

	localparam int PROD_W = RAW_W + PCT_W;

	logic [PROD_W-1:0] prod;
	logic [PCT_W-1:0]  q0;
	logic [RAW_W:0]    rem;

	// 4095 = 4096 - 1: quotient by shift, remainder is low bits plus quotient,
	// which stays below twice the divisor, so one correction step suffices
	always_comb begin
		prod = PROD_W'(raw) * PROD_W'(PCT_FULL);
		q0   = prod[PROD_W-1:RAW_W];
		rem  = {1'b0, prod[RAW_W-1:0]} + (RAW_W+1)'(q0);
		pct  = q0 + PCT_W'(rem >= {1'b0, RAW_FULL});
	end

endmodule

/* src/pstm_side.sv */
// ----------------------------------------------------------------------------
// pstm_side
// Catch, drift and update decision for one pot against its stored percent.
// ----------------------------------------------------------------------------
module pstm_side import pstm_pkg::*; (
	input  logic [PCT_W-1:0] stored,
	input  logic [PCT_W-1:0] now,
	input  logic [CFG_W-1:0] threshold,
	input  logic [CFG_W-1:0] window,
	output pstm_side_t       side
);

	logic [PCT_W-1:0] gap;
	logic             below;

	always_comb begin
		below            = now < stored;
		gap              = below ? (stored - now) : (now - stored);
		side.changed     = gap > threshold;
		side.caught      = gap <= window;
		if (side.caught) begin
			side.dir = DIR_NONE;
		end else if (below) begin
			side.dir = DIR_BELOW;
		end else begin
			side.dir = DIR_ABOVE;
		end
		// a change that is not caught leaves the store alone
		side.store_next  = (side.changed && side.caught) ? now : stored;
	end

endmodule

/* src/pot_soft_takeover_mixer.sv */
// ----------------------------------------------------------------------------
// pot_soft_takeover_mixer
// Soft-takeover of two pots over a set of mixer levels with joystick select.
// ----------------------------------------------------------------------------
//  channel   | dir | handshake    | payload
//  ----------+-----+--------------+-------------------------------------------
//  samples   | in  | valid/ready  | left_raw, right_raw, joystick
//  result    | out | valid/ready  | levels, percents, caught, drift, changed
//  cfg       | in  | cfg_we       | cfg_idx, cfg_wdata (threshold, window)
//
//  One request per cycle sustained while the result is taken; a request leaves
//  through the input register, then the result register.
//  Store and level are updated as a request leaves the input register, so the
//  next request in line always sees the updated state.
//  A stalled result holds; the input register still takes one more request.
//  Reset clears stores, level and valids; registers return to 2 and 20.
// ----------------------------------------------------------------------------
module pot_soft_takeover_mixer import pstm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CIDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]  cfg_wdata,
	pstm_in_if.sink           samples,
	pstm_out_if.source        result
);

	logic [CFG_W-1:0] threshold_q;
	logic [CFG_W-1:0] window_q;

	logic [PCT_W-1:0] left_store_q [NUM_LEVELS];
	logic [PCT_W-1:0] right_store_q [NUM_LEVELS];
	logic [LVL_W-1:0] level_q;

	logic             valid_s1;
	logic [RAW_W-1:0] left_raw_s1;
	logic [RAW_W-1:0] right_raw_s1;
	logic [JOY_W-1:0] joystick_s1;

	logic                    valid_s2;
	logic [LVL_OW-1:0]       level_used_s2;
	logic [LVL_OW-1:0]       level_next_s2;
	logic [PCT_W-1:0]        left_pct_s2;
	logic [PCT_W-1:0]        right_pct_s2;
	logic                    left_caught_s2;
	logic                    right_caught_s2;
	logic signed [DIR_W-1:0] left_dir_s2;
	logic signed [DIR_W-1:0] right_dir_s2;
	logic                    changed_s2;

	logic             advance;
	logic             fire;
	logic [PCT_W-1:0] left_now;
	logic [PCT_W-1:0] right_now;
	pstm_side_t       left_side;
	pstm_side_t       right_side;
	logic [LVL_W-1:0] level_nxt;

	assign advance       = !valid_s2 || result.ready;
	assign fire          = valid_s1 && advance;
	assign samples.ready = !valid_s1 || advance;

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RST;
			window_q    <= WINDOW_RST;
		end else if (cfg_we) begin
			case (cfg_idx)
				CFG_THRESHOLD: threshold_q <= cfg_wdata;
				CFG_WINDOW:    window_q    <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (samples.ready) begin
			valid_s1 <= samples.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (samples.valid && samples.ready) begin
			left_raw_s1  <= samples.left_raw;
			right_raw_s1 <= samples.right_raw;
			joystick_s1  <= samples.joystick;
		end
	end

	pstm_scale u_scale_left (
		.raw (left_raw_s1),
		.pct (left_now)
	);

	pstm_scale u_scale_right (
		.raw (right_raw_s1),
		.pct (right_now)
	);

	pstm_side u_side_left (
		.stored    (left_store_q[level_q]),
		.now       (left_now),
		.threshold (threshold_q),
		.window    (window_q),
		.side      (left_side)
	);

	pstm_side u_side_right (
		.stored    (right_store_q[level_q]),
		.now       (right_now),
		.threshold (threshold_q),
		.window    (window_q),
		.side      (right_side)
	);

	// step the level with wraparound; the unused code counts as no event
	always_comb begin
		case (joystick_s1)
			JOY_UP:   level_nxt = (level_q == LVL_W'(NUM_LEVELS - 1)) ?
				'0 : level_q + LVL_W'(1);
			JOY_DOWN: level_nxt = (level_q == '0) ?
				LVL_W'(NUM_LEVELS - 1) : level_q - LVL_W'(1);
			default:  level_nxt = level_q;
		endcase
	end

	// state update as the request moves to the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q <= '0;
			for (int i = 0; i < NUM_LEVELS; i++) begin
				left_store_q[i]  <= '0;
				right_store_q[i] <= '0;
			end
		end else if (fire) begin
			level_q                <= level_nxt;
			left_store_q[level_q]  <= left_side.store_next;
			right_store_q[level_q] <= right_side.store_next;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			level_used_s2   <= LVL_OW'(level_q);
			level_next_s2   <= LVL_OW'(level_nxt);
			left_pct_s2     <= left_side.store_next;
			right_pct_s2    <= right_side.store_next;
			left_caught_s2  <= left_side.caught;
			right_caught_s2 <= right_side.caught;
			left_dir_s2     <= left_side.dir;
			right_dir_s2    <= right_side.dir;
			changed_s2      <= left_side.changed || right_side.changed;
		end
	end

	assign result.valid           = valid_s2;
	assign result.level_used      = level_used_s2;
	assign result.level_next      = level_next_s2;
	assign result.left_percent    = left_pct_s2;
	assign result.right_percent   = right_pct_s2;
	assign result.left_caught     = left_caught_s2;
	assign result.right_caught    = right_caught_s2;
	assign result.left_drift_dir  = left_dir_s2;
	assign result.right_drift_dir = right_dir_s2;
	assign result.display_changed = changed_s2;

	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= LVL_W'(NUM_LEVELS - 1))
		else $error("level out of range");

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (left_pct_s2 <= PCT_FULL) && (right_pct_s2 <= PCT_FULL))
		else $error("stored percent above full scale");

	a_drift_caught: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> (left_caught_s2 == (left_dir_s2 == DIR_NONE)) &&
			(right_caught_s2 == (right_dir_s2 == DIR_NONE)))
		else $error("drift direction disagrees with caught flag");

	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !advance |=> valid_s1 && $stable(left_raw_s1) && $stable(joystick_s1))
		else $error("stalled request lost");

endmodule

/* tb/pstm_mix_check.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pstm_mix_check
// Watches the sample and result channels and the register port. It keeps its
// own copy of the level stores, current level and registers, predicts one
// result per accepted request, and compares results field by field in order.
// ----------------------------------------------------------------------------
module pstm_mix_check import pstm_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [CIDX_W-1:0] cfg_idx,
	input  logic [CFG_W-1:0]  cfg_wdata,
	pstm_in_if                samples,
	pstm_out_if               result,
	output int                fail_count,
	output int                pending,
	output int                compared
);

	typedef struct {
		logic [LVL_OW-1:0]       level_used;
		logic [LVL_OW-1:0]       level_next;
		logic [PCT_W-1:0]        left_percent;
		logic [PCT_W-1:0]        right_percent;
		logic                    left_caught;
		logic                    right_caught;
		logic signed [DIR_W-1:0] left_dir;
		logic signed [DIR_W-1:0] right_dir;
		logic                    changed;
	} mix_result_t;

	mix_result_t      mix_results_q[$];
	logic [PCT_W-1:0] left_store[NUM_LEVELS];
	logic [PCT_W-1:0] right_store[NUM_LEVELS];
	int unsigned      level;
	logic [CFG_W-1:0] threshold;
	logic [CFG_W-1:0] window;

	function automatic int unsigned scale_pct(logic [RAW_W-1:0] raw);
		return (int'(raw) * int'(PCT_FULL)) / int'(RAW_FULL);
	endfunction

	function automatic pstm_side_t judge_side(logic [PCT_W-1:0] stored, int unsigned now);
		int unsigned gap;
		pstm_side_t  s;
		gap = (now > stored) ? now - stored : stored - now;
		s.changed = gap > threshold;
		s.caught  = gap <= window;
		if (s.caught) begin
			s.dir = DIR_NONE;
		end else begin
			s.dir = (now < stored) ? DIR_BELOW : DIR_ABOVE;
		end
		// take the new position only once the pot has caught up
		s.store_next = (s.changed && s.caught) ? PCT_W'(now) : stored;
		return s;
	endfunction

	function automatic mix_result_t mix_tick(logic [RAW_W-1:0] l_raw, logic [RAW_W-1:0] r_raw,
			logic [JOY_W-1:0] joy);
		int unsigned lvl;
		int unsigned nxt;
		pstm_side_t  ls;
		pstm_side_t  rs;
		mix_result_t r;
		lvl = level;
		nxt = lvl;
		ls = judge_side(left_store[lvl], scale_pct(l_raw));
		rs = judge_side(right_store[lvl], scale_pct(r_raw));
		left_store[lvl]  = ls.store_next;
		right_store[lvl] = rs.store_next;
		if (joy == JOY_UP) begin
			nxt = (lvl + 1) % NUM_LEVELS;
		end else if (joy == JOY_DOWN) begin
			nxt = (lvl + NUM_LEVELS - 1) % NUM_LEVELS;
		end
		level = nxt;
		r.level_used    = LVL_OW'(lvl);
		r.level_next    = LVL_OW'(nxt);
		r.left_percent  = ls.store_next;
		r.right_percent = rs.store_next;
		r.left_caught   = ls.caught;
		r.right_caught  = rs.caught;
		r.left_dir      = ls.dir;
		r.right_dir     = rs.dir;
		r.changed       = ls.changed | rs.changed;
		return r;
	endfunction

	task automatic check_field(string name, logic signed [31:0] want, logic signed [31:0] got);
		if (got !== want) begin
			fail_count++;
			$display("%0t: %s mismatch: expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		mix_result_t e;
		if (!arst_n) begin
			for (int i = 0; i < NUM_LEVELS; i++) begin
				left_store[i]  = '0;
				right_store[i] = '0;
			end
			level      = 0;
			threshold  = THRESHOLD_RST;
			window     = WINDOW_RST;
			mix_results_q.delete();
			pending    = 0;
			fail_count = 0;
			compared   = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx_t'(cfg_idx))
					CFG_THRESHOLD: threshold = cfg_wdata;
					CFG_WINDOW:    window    = cfg_wdata;
					default:       ;
				endcase
			end
			if (samples.valid && samples.ready) begin
				mix_results_q.push_back(mix_tick(samples.left_raw, samples.right_raw,
					samples.joystick));
			end
			if (result.valid && result.ready) begin
				if (mix_results_q.size() == 0) begin
					fail_count++;
					$display("%0t: result with no request waiting, expected none, actual level %0d",
						$time, result.level_used);
				end else begin
					e = mix_results_q.pop_front();
					compared++;
					check_field("level_used", e.level_used, result.level_used);
					check_field("level_next", e.level_next, result.level_next);
					check_field("left_percent", e.left_percent, result.left_percent);
					check_field("right_percent", e.right_percent, result.right_percent);
					check_field("left_caught", e.left_caught, result.left_caught);
					check_field("right_caught", e.right_caught, result.right_caught);
					check_field("left_drift_dir", e.left_dir, result.left_drift_dir);
					check_field("right_drift_dir", e.right_dir, result.right_drift_dir);
					check_field("display_changed", e.changed, result.display_changed);
				end
			end
			pending = mix_results_q.size();
		end
	end

endmodule

/* tb/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the pot soft-takeover mixer: a directed pass over catch,
// threshold and level wrap cases, then phases of pot random walks under
// several register settings with random idling on both channels, one long
// result hold-off, and a drain before every register write.
// ----------------------------------------------------------------------------
module tb;
	import pstm_pkg::*;

	localparam int CYCLE_LIMIT     = 200000;
	localparam int HOLD_OFF_CYCLES = 60;
	localparam int PHASES          = 7;
	localparam int PHASE_ITEMS     = 70;

	logic              clk;
	logic              arst_n;
	logic              cfg_we;
	logic [CIDX_W-1:0] cfg_idx;
	logic [CFG_W-1:0]  cfg_wdata;

	int fail_count;
	int pending;
	int compared;
	int sent;
	int cycles;
	int src_idle_pct;
	int snk_idle_pct;
	int settings_used;
	int knob_l;
	int knob_r;
	int hold_off_reqs;
	int hold_off_done;

	pstm_in_if  samples_if ();
	pstm_out_if result_if ();

	pot_soft_takeover_mixer DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata),
		.samples   (samples_if),
		.result    (result_if)
	);

	pstm_mix_check mix_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_wdata  (cfg_wdata),
		.samples    (samples_if),
		.result     (result_if),
		.fail_count (fail_count),
		.pending    (pending),
		.compared   (compared)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results still pending", cycles, pending);
			$display("TEST FAILED");
			$finish;
		end
	end

	// result side: random stalls, plus the long hold-off on request
	initial begin
		result_if.ready = 1'b0;
		hold_off_done   = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off_done != hold_off_reqs) begin
				hold_off_done++;
				result_if.ready <= 1'b0;
				repeat (HOLD_OFF_CYCLES) @(posedge clk);
				result_if.ready <= 1'b1;
			end else if (snk_idle_pct != 0 && $urandom_range(0, 99) < snk_idle_pct) begin
				result_if.ready <= 1'b0;
				repeat ($urandom_range(1, 13)) @(posedge clk);
				result_if.ready <= 1'b1;
			end else begin
				result_if.ready <= 1'b1;
			end
		end
	end

	// smallest raw sample that scales to pct
	function automatic logic [RAW_W-1:0] raw_for(int unsigned pct);
		return RAW_W'((pct * int'(RAW_FULL) + int'(PCT_FULL) - 1) / int'(PCT_FULL));
	endfunction

	// any raw sample that scales to pct
	function automatic logic [RAW_W-1:0] jitter_raw(int unsigned pct);
		int unsigned lo;
		int unsigned hi;
		lo = int'(raw_for(pct));
		hi = (pct >= PCT_FULL) ? int'(RAW_FULL) : int'(raw_for(pct + 1)) - 1;
		return RAW_W'($urandom_range(hi, lo));
	endfunction

	task automatic push_sample(logic [RAW_W-1:0] l_raw, logic [RAW_W-1:0] r_raw,
			logic [JOY_W-1:0] joy);
		if (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
			samples_if.valid <= 1'b0;
			repeat ($urandom_range(1, 13)) @(posedge clk);
		end
		samples_if.valid     <= 1'b1;
		samples_if.left_raw  <= l_raw;
		samples_if.right_raw <= r_raw;
		samples_if.joystick  <= joy;
		do @(posedge clk); while (!samples_if.ready);
		sent++;
	endtask

	task automatic push_pct(int unsigned l_pct, int unsigned r_pct, logic [JOY_W-1:0] joy);
		push_sample(raw_for(l_pct), raw_for(r_pct), joy);
	endtask

	// stop offering and wait until every request has its result
	task automatic settle();
		samples_if.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_cfg(logic [CFG_W-1:0] thr, logic [CFG_W-1:0] win);
		settle();
		cfg_we    <= 1'b1;
		cfg_idx   <= CFG_THRESHOLD;
		cfg_wdata <= thr;
		@(posedge clk);
		cfg_idx   <= CFG_WINDOW;
		cfg_wdata <= win;
		@(posedge clk);
		cfg_we    <= 1'b0;
		@(posedge clk);
		settings_used++;
	endtask

	function automatic int walk(int pos);
		int p;
		p = pos + $urandom_range(0, 12) - 6;
		if (p < 0) p = 0;
		if (p > int'(PCT_FULL)) p = int'(PCT_FULL);
		return p;
	endfunction

	task automatic run_phase(int count, bit with_hold);
		logic [RAW_W-1:0] l_raw;
		logic [RAW_W-1:0] r_raw;
		logic [JOY_W-1:0] joy;
		int unsigned      pick;
		for (int i = 0; i < count; i++) begin
			if (with_hold && i == 20) hold_off_reqs++;
			pick = $urandom_range(0, 99);
			if (pick < 8) begin
				// jump a pot away so it has to be caught again
				knob_l = $urandom_range(0, PCT_FULL);
				knob_r = $urandom_range(0, PCT_FULL);
			end else begin
				knob_l = walk(knob_l);
				knob_r = walk(knob_r);
			end
			if (pick >= 85) begin
				l_raw = RAW_W'($urandom_range(0, RAW_FULL));
				r_raw = RAW_W'($urandom_range(0, RAW_FULL));
			end else begin
				l_raw = jitter_raw(knob_l);
				r_raw = jitter_raw(knob_r);
			end
			joy = ($urandom_range(0, 99) < 80) ? JOY_NONE : JOY_W'($urandom_range(1, 3));
			push_sample(l_raw, r_raw, joy);
		end
	endtask

	initial begin
		logic [CFG_W-1:0] thr;
		logic [CFG_W-1:0] win;
		arst_n               = 1'b0;
		cfg_we               = 1'b0;
		cfg_idx              = CFG_THRESHOLD;
		cfg_wdata            = '0;
		samples_if.valid     = 1'b0;
		samples_if.left_raw  = '0;
		samples_if.right_raw = '0;
		samples_if.joystick  = JOY_NONE;
		sent                 = 0;
		settings_used        = 1;
		hold_off_reqs        = 0;
		src_idle_pct         = 0;
		snk_idle_pct         = 0;
		knob_l               = 50;
		knob_r               = 50;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed pass on reset registers (threshold 2, window 20)
		push_sample('0, '0, JOY_NONE);
		push_sample(RAW_FULL, RAW_FULL, JOY_NONE);   // changed but not caught
		push_pct(15, 2, JOY_NONE);                   // right exactly at threshold
		push_pct(35, 3, JOY_NONE);                   // left at window edge
		push_pct(56, 0, JOY_NONE);                   // left one past window, above
		push_pct(14, 0, JOY_NONE);                   // left one past window, below
		push_pct(35, 0, JOY_UP);
		push_sample(RAW_FULL, '0, JOY_UP);
		push_sample('0, RAW_FULL, JOY_UP);           // wrap up to level 0
		push_pct(35, 0, JOY_DOWN);                   // wrap down to last level
		push_pct(10, 10, JOY_SPARE);                 // unused code holds the level
		push_pct(10, 10, JOY_DOWN);
		push_pct(0, 0, JOY_DOWN);
		push_sample(12'd40, 12'd41, JOY_NONE);
		push_sample(12'hAAA, 12'h555, JOY_SPARE);
		push_sample(12'h555, 12'hAAA, JOY_NONE);
		push_sample(RAW_FULL - 1, RAW_FULL - 1, JOY_NONE);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: begin thr = 7'd2;   win = 7'd20;  end
				1: begin thr = 7'd0;   win = 7'd100; end
				2: begin thr = 7'd100; win = 7'd0;   end
				3: begin thr = 7'd127; win = 7'd127; end
				4: begin thr = 7'd0;   win = 7'd0;   end
				default: begin
					thr = CFG_W'($urandom_range(0, 127));
					win = CFG_W'($urandom_range(0, 127));
				end
			endcase
			write_cfg(thr, win);
			if (p == PHASES - 1) begin
				src_idle_pct = 0;
				snk_idle_pct = 0;
			end else if (p == 0) begin
				src_idle_pct = 20;
				snk_idle_pct = 8;
			end else begin
				src_idle_pct = $urandom_range(0, 3) * 10;
				snk_idle_pct = $urandom_range(0, 2) * 6;
			end
			run_phase(PHASE_ITEMS, p == 0);
		end
		settle();
		repeat (10) @(posedge clk);

		$display("%0d sample requests, %0d results compared over %0d register settings,",
			sent, compared, settings_used);
		$display("with level wrap both ways, a %0d-cycle result hold-off and drains between phases",
			HOLD_OFF_CYCLES);
		if (fail_count == 0 && pending == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("%0d mismatches, %0d results missing", fail_count, pending);
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule
